### design/mte_pkg.sv
// Shared types and constants for the marker text extractor.
// Used by the front, queue and back modules; depends on nothing.
`default_nettype none

package mte_pkg;

  localparam int MARK_LEN = 21;
  localparam int WIN_LEN  = 20;
  localparam int TAIL_LEN = 4;
  localparam int Q_DEPTH  = 4;

  // First character sits in the highest byte
  localparam logic [MARK_LEN*8-1:0] START_MARK = "Sorry about that. -->";
  localparam logic [TAIL_LEN*8-1:0] END_TAG    = "/div";
  localparam logic [7:0]            CHAR_LT    = 8'h3c;
  localparam logic [7:0]            CHAR_GT    = 8'h3e;

  typedef enum logic [1:0] {
    KIND_TEXT   = 2'd0,
    KIND_END    = 2'd1,
    KIND_NOMARK = 2'd2,
    KIND_EARLY  = 2'd3
  } kind_t;

  // What one page byte produces: optional text word, optional closing status
  typedef struct packed {
    logic       has_text;
    logic [7:0] text_byte;
    logic       has_stat;
    kind_t      stat_kind;
  } entry_t;

endpackage

`default_nettype wire

### design/mte_front.sv
// Front end: marker search, tag tracking and classification of each page byte.
// Depends on mte_pkg; pushes result entries into mte_queue.
`default_nettype none

module mte_front
  import mte_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       acc,
  input  wire logic [7:0] page_byte,
  input  wire logic       last_byte,
  output entry_t          push_entry,
  output logic            push
);

  typedef enum logic [1:0] {
    MODE_SEARCH,
    MODE_TEXT,
    MODE_TAG,
    MODE_DONE
  } mode_t;

  mode_t                    mode_r, mode_nxt;
  logic [WIN_LEN*8-1:0]     window_r, window_nxt;
  logic [2:0]               tag_len_r, tag_len_nxt;
  logic [TAIL_LEN*8-1:0]    tail_r, tail_nxt;
  logic                     hit;
  logic                     closed;

  assign hit = (window_r == START_MARK[MARK_LEN*8-1:8]) && (page_byte == START_MARK[7:0]);

  always_comb begin
    mode_nxt   = mode_r;
    window_nxt = window_r;
    tag_len_nxt = tag_len_r;
    tail_nxt   = tail_r;
    closed     = 1'b0;
    push_entry = '{has_text: 1'b0, text_byte: page_byte, has_stat: 1'b0, stat_kind: KIND_END};

    case (mode_r)
      MODE_SEARCH: begin
        if (hit) begin
          mode_nxt = MODE_TEXT;
        end else begin
          window_nxt = {window_r[WIN_LEN*8-9:0], page_byte};
        end
      end
      MODE_TEXT: begin
        if (page_byte == CHAR_LT) begin
          mode_nxt    = MODE_TAG;
          tag_len_nxt = '0;
          tail_nxt    = '0;
        end else begin
          push_entry.has_text = 1'b1;
        end
      end
      MODE_TAG: begin
        if (page_byte == CHAR_GT) begin
          if (tag_len_r == 3'(TAIL_LEN) && tail_r == END_TAG) begin
            push_entry.has_stat  = 1'b1;
            push_entry.stat_kind = KIND_END;
            closed               = 1'b1;
            mode_nxt             = MODE_DONE;
          end else begin
            mode_nxt = MODE_TEXT;
          end
        end else begin
          tail_nxt = {tail_r[TAIL_LEN*8-9:0], page_byte};
          if (tag_len_r != 3'd7) begin
            tag_len_nxt = tag_len_r + 3'd1;
          end
        end
      end
      default: begin
        mode_nxt = MODE_DONE;
      end
    endcase

    // Close the page and rearm
    if (last_byte) begin
      if (!closed) begin
        if (mode_nxt == MODE_SEARCH) begin
          push_entry.has_stat  = 1'b1;
          push_entry.stat_kind = KIND_NOMARK;
        end else if (mode_nxt == MODE_TEXT || mode_nxt == MODE_TAG) begin
          push_entry.has_stat  = 1'b1;
          push_entry.stat_kind = KIND_EARLY;
        end
      end
      mode_nxt    = MODE_SEARCH;
      window_nxt  = '0;
      tag_len_nxt = '0;
      tail_nxt    = '0;
    end
  end

  assign push = acc && (push_entry.has_text || push_entry.has_stat);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_SEARCH;
      window_r  <= '0;
      tag_len_r <= '0;
      tail_r    <= '0;
    end else if (acc) begin
      mode_r    <= mode_nxt;
      window_r  <= window_nxt;
      tag_len_r <= tag_len_nxt;
      tail_r    <= tail_nxt;
    end
  end

endmodule

`default_nettype wire

### design/mte_queue.sv
// Short FIFO of result entries between front and back.
// Depends on mte_pkg for entry_t and Q_DEPTH.
`default_nettype none

module mte_queue
  import mte_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  entry_t    push_entry,
  input  wire logic pop,
  output logic      full,
  output logic      q_valid,
  output entry_t    q_entry
);

  localparam int PW = $clog2(Q_DEPTH);

  entry_t          mem_r [Q_DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [PW:0]     count_r;

  assign full    = (count_r == (PW+1)'(Q_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_entry = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + (PW+1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (PW+1)'(1);
      end
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n) pop |-> q_valid)
    else $error("pop from empty queue");
  a_entry_useful: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (push_entry.has_text || push_entry.has_stat))
    else $error("empty entry pushed");

endmodule

`default_nettype wire

### design/mte_back.sv
// Back end: turns queued entries into output words, text before status.
// Depends on mte_pkg; drains mte_queue into the registered output stage.
`default_nettype none

module mte_back
  import mte_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_valid,
  input  entry_t           q_entry,
  output logic             pop,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,
  output logic [1:0]       out_tuser,
  output logic             out_tlast
);

  logic       valid_r, valid_nxt;
  logic [7:0] data_r, data_nxt;
  kind_t      kind_r, kind_nxt;
  logic       last_r, last_nxt;
  logic       text_sent_r, text_sent_nxt;
  logic       load;

  assign load = q_valid && (!valid_r || out_tready);

  always_comb begin
    valid_nxt     = valid_r;
    data_nxt      = data_r;
    kind_nxt      = kind_r;
    last_nxt      = last_r;
    text_sent_nxt = text_sent_r;
    pop           = 1'b0;
    if (load) begin
      valid_nxt = 1'b1;
      if (q_entry.has_text && !text_sent_r) begin
        data_nxt      = q_entry.text_byte;
        kind_nxt      = KIND_TEXT;
        last_nxt      = 1'b0;
        // Hold the entry when its status word still has to go out
        pop           = !q_entry.has_stat;
        text_sent_nxt = q_entry.has_stat;
      end else begin
        data_nxt      = '0;
        kind_nxt      = q_entry.stat_kind;
        last_nxt      = 1'b1;
        pop           = 1'b1;
        text_sent_nxt = 1'b0;
      end
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= 1'b0;
      text_sent_r <= 1'b0;
    end else begin
      valid_r     <= valid_nxt;
      text_sent_r <= text_sent_nxt;
    end
    data_r <= data_nxt;
    kind_r <= kind_nxt;
    last_r <= last_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = kind_r;
  assign out_tlast  = last_r;

  a_text_not_final: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && kind_r == KIND_TEXT) |-> !last_r)
    else $error("text word marked final");
  a_status_final: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && kind_r != KIND_TEXT) |-> (last_r && data_r == '0))
    else $error("status word malformed");
  a_split_pending: assert property (@(posedge clk) disable iff (!rst_n)
    text_sent_r |-> (q_valid && q_entry.has_stat && q_entry.has_text))
    else $error("text sent flag without split entry");

endmodule

`default_nettype wire

### design/marker_text_extractor.sv
// Marker text extractor: one page byte in per cycle while the queue is not full, one
// result word out per cycle while out_tready is high. Bytes before the start marker
// "Sorry about that. -->" are scanned against a 20-byte history window compared in
// parallel; after it, bytes outside <...> tags come out as text words (tuser 0) until
// a </div> tag, which yields an end status (tuser 1). A page byte flagged tlast closes
// the page with a status word if none came yet (2: marker missing, 3: page ended early)
// and rearms the block. Every status word carries tlast. A last byte that carries both
// a text word and a status word goes out as two words from one queue entry, and a
// four-entry queue between the classifier and the output stage absorbs that. An accepted
// byte's entry is queued, then registered in the output stage. Input is ready after reset.
`default_nettype none

module marker_text_extractor
  import mte_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] page_byte
  input  wire logic       in_tlast,   // last_byte
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] text_byte
  output logic [1:0]      out_tuser,  // [1:0] kind
  output logic            out_tlast   // final_res
);

  logic   acc;
  logic   push;
  entry_t push_entry;
  logic   full;
  logic   pop;
  logic   q_valid;
  entry_t q_entry;

  assign in_tready = !full;
  assign acc       = in_tvalid && in_tready;

  mte_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .page_byte  (in_tdata),
    .last_byte  (in_tlast),
    .push_entry (push_entry),
    .push       (push)
  );

  mte_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (full),
    .q_valid    (q_valid),
    .q_entry    (q_entry)
  );

  mte_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_entry    (q_entry),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

### dv/marker_text_extractor_tb.sv
// Self-checking testbench for marker_text_extractor: drives page bytes over the input
// stream and checks every result word against an in-bench model of the extractor.
// Depends on mte_pkg (kind codes and marker constants) and the design top level.
`timescale 1ns / 1ps

module marker_text_extractor_tb;
  import mte_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 200;
  localparam int RANDOM_BYTES = 830;

  typedef enum logic [1:0] {
    PG_SCAN = 2'd0,
    PG_TEXT = 2'd1,
    PG_TAG  = 2'd2,
    PG_DONE = 2'd3
  } page_mode_t;

  typedef struct {
    logic [7:0] text;
    kind_t      kind;
    logic       fin;
  } result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;   // [7:0] page_byte
  logic       in_tlast = 1'b0;    // last_byte
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;          // [7:0] text_byte
  logic [1:0] out_tuser;          // [1:0] kind
  logic       out_tlast;          // final_res

  // Model state
  page_mode_t pg_mode;
  logic [7:0] history [WIN_LEN];
  logic [2:0] tag_len;
  logic [7:0] tag_tail [TAIL_LEN];

  result_t    expected_words [$];
  logic [7:0] page_buf [$];
  int         error_count = 0;
  int         bytes_sent = 0;
  int         cycle_count = 0;

  // Traffic shaping
  int burst_max = 1;
  int gap_max = 0;
  int burst_left = 1;
  int stall_pct = 0;
  int hold_req_count = 0;
  int hold_seen = 0;
  int hold_left = 0;

  marker_text_extractor u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] mark_char(input int k);
    return START_MARK[(MARK_LEN-1-k)*8 +: 8];
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(255));
  endfunction

  task automatic clear_page_model();
    int k;
    pg_mode = PG_SCAN;
    for (k = 0; k < WIN_LEN; k++) history[k] = 8'h00;
    tag_len = 3'd0;
    for (k = 0; k < TAIL_LEN; k++) tag_tail[k] = 8'h00;
  endtask

  task automatic expect_word(input logic [7:0] b, input kind_t k, input logic f);
    result_t r;
    r.text = b;
    r.kind = k;
    r.fin  = f;
    expected_words.push_back(r);
  endtask

  task automatic predict_page_byte(input logic [7:0] b, input logic lst);
    logic hit;
    logic closed;
    int k;
    closed = 1'b0;
    case (pg_mode)
      PG_SCAN: begin
        hit = (b == mark_char(MARK_LEN-1));
        for (k = 0; k < WIN_LEN; k++) if (history[k] != mark_char(k)) hit = 1'b0;
        if (hit) begin
          pg_mode = PG_TEXT;
        end else begin
          for (k = 0; k < WIN_LEN-1; k++) history[k] = history[k+1];
          history[WIN_LEN-1] = b;
        end
      end
      PG_TEXT: begin
        if (b == CHAR_LT) begin
          pg_mode = PG_TAG;
          tag_len = 3'd0;
          for (k = 0; k < TAIL_LEN; k++) tag_tail[k] = 8'h00;
        end else begin
          expect_word(b, KIND_TEXT, 1'b0);
        end
      end
      PG_TAG: begin
        if (b == CHAR_GT) begin
          if (tag_len == 3'(TAIL_LEN) &&
              {tag_tail[0], tag_tail[1], tag_tail[2], tag_tail[3]} == END_TAG) begin
            expect_word(8'h00, KIND_END, 1'b1);
            closed = 1'b1;
            pg_mode = PG_DONE;
          end else begin
            pg_mode = PG_TEXT;
          end
        end else begin
          for (k = 0; k < TAIL_LEN-1; k++) tag_tail[k] = tag_tail[k+1];
          tag_tail[TAIL_LEN-1] = b;
          if (tag_len < 3'd7) tag_len = tag_len + 3'd1;
        end
      end
      default: ;
    endcase
    if (lst) begin
      if (!closed) begin
        if (pg_mode == PG_SCAN) expect_word(8'h00, KIND_NOMARK, 1'b1);
        else if (pg_mode == PG_TEXT || pg_mode == PG_TAG) expect_word(8'h00, KIND_EARLY, 1'b1);
      end
      clear_page_model();
    end
  endtask

  // Offer one word, wait for the handshake, then maybe open a gap
  task automatic send_byte(input logic [7:0] b, input logic lst);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= lst;
    do @(posedge clk); while (!in_tready);
    predict_page_byte(b, lst);
    bytes_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      gap = $urandom_range(gap_max);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(burst_max, 1);
    end
  endtask

  task automatic set_traffic(input int bmax, input int gmax, input int spct);
    burst_max  = bmax;
    gap_max    = gmax;
    stall_pct  = spct;
    burst_left = 1;
  endtask

  task automatic start_page();
    page_buf.delete();
  endtask

  task automatic add_byte(input logic [7:0] b);
    page_buf.push_back(b);
  endtask

  task automatic add_str(input string s);
    int i;
    for (i = 0; i < s.len(); i++) page_buf.push_back(8'(s[i]));
  endtask

  task automatic add_marker();
    int k;
    for (k = 0; k < MARK_LEN; k++) page_buf.push_back(mark_char(k));
  endtask

  task automatic send_page();
    int i;
    for (i = 0; i < page_buf.size(); i++) send_byte(page_buf[i], i == page_buf.size() - 1);
  endtask

  // Receiver: random stalls, plus a long hold whenever a test asks for one
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_seen != hold_req_count) begin
      out_tready <= 1'b0;
      hold_seen  <= hold_req_count;
      hold_left  <= HOLD_CYCLES;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Compare each accepted result word with the oldest expectation
  always @(posedge clk) begin
    result_t r;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word expected none actual data %02h kind %0d last %0b",
                 $time, out_tdata, out_tuser, out_tlast);
        error_count++;
      end else begin
        r = expected_words.pop_front();
        if (out_tdata !== r.text) begin
          $display("%0t: text_byte mismatch expected %02h actual %02h", $time, r.text, out_tdata);
          error_count++;
        end
        if (out_tuser !== r.kind) begin
          $display("%0t: kind mismatch expected %0d actual %0d", $time, r.kind, out_tuser);
          error_count++;
        end
        if (out_tlast !== r.fin) begin
          $display("%0t: final_res mismatch expected %0b actual %0b", $time, r.fin, out_tlast);
          error_count++;
        end
      end
    end
  end

  task automatic test_no_marker();
    start_page();
    add_byte(8'h00);
    add_byte(8'hff);
    add_byte(CHAR_LT);
    add_byte(CHAR_GT);
    send_page();
  endtask

  task automatic test_marker_at_page_end();
    start_page();
    add_marker();
    send_page();
  endtask

  task automatic test_text_and_tags();
    start_page();
    add_str("Sorry ");
    add_marker();
    add_byte(8'h00);
    add_byte(8'hff);
    add_byte(CHAR_GT);
    add_str("<>a<b<c>d</dix>e<x/div>f<aaaa/div>g</di>h</div>");
    add_str("zz<q>");
    send_page();
  endtask

  task automatic test_end_tag_on_last();
    start_page();
    add_marker();
    add_str("t</div>");
    send_page();
  endtask

  task automatic test_page_ends_in_text();
    start_page();
    add_marker();
    add_str("ok");
    send_page();
  endtask

  task automatic test_page_ends_in_tag();
    start_page();
    add_marker();
    add_str("x<di");
    send_page();
  endtask

  // Hold the result side off while text keeps coming, so the input must stall
  task automatic test_long_hold();
    int i;
    set_traffic(64, 0, 0);
    start_page();
    add_marker();
    send_page();
    start_page();
    add_marker();
    for (i = 0; i < 40; i++) add_byte(8'h41 + 8'(i % 26));
    add_str("</div>");
    hold_req_count++;
    send_page();
  endtask

  task automatic add_random_tag();
    int n;
    logic [7:0] c;
    add_byte(CHAR_LT);
    case ($urandom_range(5))
      0: ;
      1: add_str("/div");
      2: begin
        n = $urandom_range(6, 1);
        repeat (n) begin
          c = rand_byte();
          if (c == CHAR_GT) c = CHAR_LT;
          add_byte(c);
        end
      end
      3: begin
        add_str("/di");
        c = 8'($urandom_range(8'h7a, 8'h61));
        add_byte(c);
      end
      4: add_str("aaaa/div");
      default: add_str("x/div");
    endcase
    add_byte(CHAR_GT);
  endtask

  task automatic test_random_pages();
    int start_count;
    int pick;
    int n;
    int idx;
    start_count = bytes_sent;
    while (bytes_sent - start_count < RANDOM_BYTES) begin
      if ($urandom_range(3) == 0) begin
        case ($urandom_range(3))
          0: set_traffic(32, 0, 0);
          1: set_traffic($urandom_range(8, 1), $urandom_range(6), $urandom_range(60));
          2: set_traffic(4, 2, 80);
          default: set_traffic(16, 12, 20);
        endcase
      end
      start_page();
      pick = $urandom_range(99);
      if (pick < 70) begin
        n = $urandom_range(6);
        repeat (n) add_byte(rand_byte());
        if ($urandom_range(3) == 0) add_str("Sorry ab");
        add_marker();
        n = $urandom_range(6);
        repeat (n) begin
          if ($urandom_range(1)) begin
            repeat ($urandom_range(8)) add_byte(rand_byte());
          end else begin
            add_random_tag();
          end
        end
        if ($urandom_range(3) != 0) begin
          add_str("</div>");
          repeat ($urandom_range(3)) add_byte(rand_byte());
        end
        if ($urandom_range(6) == 0) begin
          idx = $urandom_range(page_buf.size() - 1, 1);
          while (page_buf.size() > idx) void'(page_buf.pop_back());
        end
      end else if (pick < 85) begin
        n = $urandom_range(12, 1);
        repeat (n) add_byte(rand_byte());
      end else begin
        add_marker();
        idx = $urandom_range(MARK_LEN - 1);
        page_buf[idx] = page_buf[idx] ^ (8'h01 << $urandom_range(7));
        repeat ($urandom_range(8)) add_byte(rand_byte());
      end
      send_page();
    end
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("marker_text_extractor_tb NOT OK");
    $finish;
  end

  initial begin
    clear_page_model();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_traffic(1, 0, 0);
    test_no_marker();
    test_marker_at_page_end();
    set_traffic(3, 2, 30);
    test_text_and_tags();
    test_end_tag_on_last();
    test_page_ends_in_text();
    test_page_ends_in_tag();
    test_long_hold();
    test_random_pages();

    in_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("marker_text_extractor_tb OK");
    end else begin
      $display("marker_text_extractor_tb NOT OK");
    end
    $finish;
  end

endmodule

### marker_text_extractor.f
design/mte_pkg.sv
design/mte_front.sv
design/mte_queue.sv
design/mte_back.sv
design/marker_text_extractor.sv
dv/marker_text_extractor_tb.sv
